@@ hdl/obb_pkg.sv @@
package obb_pkg;

  // Fixed-point format of the rotation terms.
  localparam int TRIG_FRAC_BITS = 14;
  // Rounding shift that takes an offset product back to coordinate scale.
  localparam int ROUND_SHIFT    = 2 * TRIG_FRAC_BITS;
  // Width of the offset product (axis component times distance).
  localparam int OFF_PROD_W     = 52;
  localparam int OFF_W          = OFF_PROD_W - ROUND_SHIFT;

  // One oriented box as it arrives on the input stream.
  typedef struct packed {
    logic signed [15:0] s;
    logic signed [15:0] c;
    logic        [14:0] hy;
    logic        [14:0] hx;
    logic signed [15:0] cy;
    logic signed [15:0] cx;
  } box_t;

  // Rotation norms, cross terms and center projections.
  typedef struct packed {
    box_t               a;
    box_t               b;
    logic signed [32:0] na;
    logic signed [32:0] nb;
    logic signed [32:0] aa;
    logic signed [32:0] ab;
    logic signed [33:0] pa0;
    logic signed [33:0] pa1;
    logic signed [33:0] pb0;
    logic signed [33:0] pb1;
  } pre_t;

  // Penetration per axis and the overall hit flag.
  typedef struct packed {
    box_t               a;
    box_t               b;
    logic               hit;
    logic signed [49:0] pen_a0;
    logic signed [49:0] pen_a1;
    logic signed [49:0] pen_b0;
    logic signed [49:0] pen_b1;
    logic signed [33:0] pa0;
    logic signed [33:0] pa1;
    logic signed [33:0] pb0;
    logic signed [33:0] pb1;
  } ext_t;

  // One finished result.
  typedef struct packed {
    logic signed [15:0] second_normal_y;
    logic signed [15:0] second_normal_x;
    logic signed [15:0] second_contact_y;
    logic signed [15:0] second_contact_x;
    logic signed [15:0] first_normal_y;
    logic signed [15:0] first_normal_x;
    logic signed [15:0] first_contact_y;
    logic signed [15:0] first_contact_x;
    logic               hit;
  } res_t;

  // Saturate a signed value to 16 bits.
  function automatic logic signed [15:0] sat16(input logic signed [24:0] v);
    logic signed [15:0] r;
    if (v > 25'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -25'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

@@ hdl/obb_pair_sat_collision_core.sv @@
// Throughput: one box pair per cycle; the seven-stage multiplier pipeline
// holds up to seven pairs in flight and stalls as a whole only while a
// result waits on a low m_tready.
// Reset: rst clears every stage's valid bit; payload registers are not reset.
module obb_pair_sat_collision_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // a_center_x, a_center_y, a_half_x, a_half_y, a_cos, a_sin,
  // b_center_x, b_center_y, b_half_x, b_half_y, b_cos, b_sin, 4 zero bits
  input  logic [191:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // hit, first_contact_x, first_contact_y, first_normal_x, first_normal_y,
  // second_contact_x, second_contact_y, second_normal_x, second_normal_y,
  // 7 zero bits
  output logic [135:0] m_tdata
);
  import obb_pkg::*;

  logic en;
  logic pre_valid, ext_valid;
  pre_t pre;
  ext_t ext;
  res_t res;
  box_t box_a, box_b;

  // The whole pipeline advances unless a finished result is held up.
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  assign box_a = s_tdata[93:0];
  assign box_b = s_tdata[187:94];

  obb_pre u_pre (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s_tvalid),
    .a        (box_a),
    .b        (box_b),
    .out_valid(pre_valid),
    .out      (pre)
  );

  obb_ext u_ext (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (pre_valid),
    .in       (pre),
    .out_valid(ext_valid),
    .out      (ext)
  );

  obb_sel u_sel (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (ext_valid),
    .in       (ext),
    .out_valid(m_tvalid),
    .out      (res)
  );

  assign m_tdata = {7'b0, res};

endmodule

@@ hdl/obb_pre.sv @@
module obb_pre (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  obb_pkg::box_t a,
  input  obb_pkg::box_t b,
  output logic          out_valid,
  output obb_pkg::pre_t out
);
  import obb_pkg::*;

  logic signed [16:0] dx;
  logic signed [16:0] dy;

  logic               v1;
  box_t               a1;
  box_t               b1;
  logic signed [31:0] ca2, sa2, cb2, sb2, cacb, sasb, casb, sacb;
  logic signed [32:0] cadx, sady, sadx, cady, cbdx, sbdy, sbdx, cbdy;

  logic signed [32:0] av;
  logic signed [32:0] bv;

  // Center difference of B relative to A.
  assign dx = 17'(b.cx) - 17'(a.cx);
  assign dy = 17'(b.cy) - 17'(a.cy);

  // First stage: all rotation and projection products.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1   <= a;
      b1   <= b;
      ca2  <= a.c * a.c;
      sa2  <= a.s * a.s;
      cb2  <= b.c * b.c;
      sb2  <= b.s * b.s;
      cacb <= a.c * b.c;
      sasb <= a.s * b.s;
      casb <= a.c * b.s;
      sacb <= a.s * b.c;
      cadx <= 33'(a.c) * 33'(dx);
      sady <= 33'(a.s) * 33'(dy);
      sadx <= 33'(a.s) * 33'(dx);
      cady <= 33'(a.c) * 33'(dy);
      cbdx <= 33'(b.c) * 33'(dx);
      sbdy <= 33'(b.s) * 33'(dy);
      sbdx <= 33'(b.s) * 33'(dx);
      cbdy <= 33'(b.c) * 33'(dy);
    end
  end

  // Cross terms between the two rotations.
  assign av = 33'(cacb) + 33'(sasb);
  assign bv = 33'(sacb) - 33'(casb);

  // Second stage: norms, magnitudes of the cross terms, center projections.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out.a   <= a1;
      out.b   <= b1;
      out.na  <= 33'(ca2) + 33'(sa2);
      out.nb  <= 33'(cb2) + 33'(sb2);
      out.aa  <= av[32] ? -av : av;
      out.ab  <= bv[32] ? -bv : bv;
      out.pa0 <= 34'(cadx) + 34'(sady);
      out.pa1 <= 34'(sadx) - 34'(cady);
      out.pb0 <= -(34'(cbdx) + 34'(sbdy));
      out.pb1 <= 34'(cbdy) - 34'(sbdx);
    end
  end

endmodule

@@ hdl/obb_ext.sv @@
module obb_ext (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  obb_pkg::pre_t in,
  output logic          out_valid,
  output obb_pkg::ext_t out
);
  import obb_pkg::*;

  logic               v3;
  pre_t               p3;
  logic signed [48:0] na_hx, na_hy, nb_hx, nb_hy;
  logic signed [48:0] bhx_a, bhy_b, bhx_b, bhy_a;
  logic signed [48:0] ahx_a, ahy_b, ahx_b, ahy_a;

  logic signed [49:0] e_a0, e_a1, e_b0, e_b1;
  logic signed [49:0] d_a0, d_a1, d_b0, d_b1;
  logic signed [49:0] pen_a0, pen_a1, pen_b0, pen_b1;

  // Magnitude of a center projection, scaled up to extent scale.
  function automatic logic signed [49:0] dmag(input logic signed [33:0] p);
    logic [33:0] m;
    m = p[33] ? 34'(-p) : p;
    return $signed(50'(m) << TRIG_FRAC_BITS);
  endfunction

  // Third stage: extents of each box on each axis.
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p3    <= in;
      na_hx <= 49'(in.na) * $signed(49'(in.a.hx));
      na_hy <= 49'(in.na) * $signed(49'(in.a.hy));
      nb_hx <= 49'(in.nb) * $signed(49'(in.b.hx));
      nb_hy <= 49'(in.nb) * $signed(49'(in.b.hy));
      bhx_a <= 49'(in.aa) * $signed(49'(in.b.hx));
      bhy_b <= 49'(in.ab) * $signed(49'(in.b.hy));
      bhx_b <= 49'(in.ab) * $signed(49'(in.b.hx));
      bhy_a <= 49'(in.aa) * $signed(49'(in.b.hy));
      ahx_a <= 49'(in.aa) * $signed(49'(in.a.hx));
      ahy_b <= 49'(in.ab) * $signed(49'(in.a.hy));
      ahx_b <= 49'(in.ab) * $signed(49'(in.a.hx));
      ahy_a <= 49'(in.aa) * $signed(49'(in.a.hy));
    end
  end

  // Combined extent minus center distance gives the penetration.
  assign e_a0 = 50'(na_hx) + 50'(bhx_a) + 50'(bhy_b);
  assign e_a1 = 50'(na_hy) + 50'(bhx_b) + 50'(bhy_a);
  assign e_b0 = 50'(nb_hx) + 50'(ahx_a) + 50'(ahy_b);
  assign e_b1 = 50'(nb_hy) + 50'(ahx_b) + 50'(ahy_a);
  assign d_a0 = dmag(p3.pa0);
  assign d_a1 = dmag(p3.pa1);
  assign d_b0 = dmag(p3.pb0);
  assign d_b1 = dmag(p3.pb1);
  assign pen_a0 = e_a0 - d_a0;
  assign pen_a1 = e_a1 - d_a1;
  assign pen_b0 = e_b0 - d_b0;
  assign pen_b1 = e_b1 - d_b1;

  // Fourth stage: penetrations and the separating-axis verdict.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out.a      <= p3.a;
      out.b      <= p3.b;
      out.hit    <= !(pen_a0[49] || pen_a1[49] || pen_b0[49] || pen_b1[49]);
      out.pen_a0 <= pen_a0;
      out.pen_a1 <= pen_a1;
      out.pen_b0 <= pen_b0;
      out.pen_b1 <= pen_b1;
      out.pa0    <= p3.pa0;
      out.pa1    <= p3.pa1;
      out.pb0    <= p3.pb0;
      out.pb1    <= p3.pb1;
    end
  end

endmodule

@@ hdl/obb_sel.sv @@
module obb_sel (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  obb_pkg::ext_t in,
  output logic          out_valid,
  output obb_pkg::res_t out
);
  import obb_pkg::*;

  logic               pick_a, pick_b;
  logic signed [33:0] p_a, p_b;
  logic signed [16:0] ux_a, uy_a, ux_b, uy_b;

  logic               v5, hit5;
  logic signed [15:0] acx5, acy5, bcx5, bcy5;
  logic signed [16:0] nax5, nay5, nbx5, nby5;
  logic signed [34:0] dist_a5, dist_b5;

  logic               v6, hit6;
  logic signed [15:0] acx6, acy6, bcx6, bcy6;
  logic signed [16:0] nax6, nay6, nbx6, nby6;
  logic signed [OFF_PROD_W-1:0] oax6, oay6, obx6, oby6;

  // Offset rounded half up to coordinate scale, added to the center.
  function automatic logic signed [15:0] contact(input logic signed [15:0] ctr,
                                                 input logic signed [OFF_PROD_W-1:0] prod);
    logic signed [OFF_PROD_W-1:0] t;
    logic signed [OFF_W-1:0]      off;
    t   = prod + (OFF_PROD_W'(1) <<< (ROUND_SHIFT - 1));
    off = t[OFF_PROD_W-1:ROUND_SHIFT];
    return sat16(25'(ctr) + 25'(off));
  endfunction

  // The later of two equal penetrations never wins; opposite edges repeat.
  assign pick_a = in.pen_a1 < in.pen_a0;
  assign pick_b = in.pen_b1 < in.pen_b0;
  assign p_a    = pick_a ? in.pa1 : in.pa0;
  assign p_b    = pick_b ? in.pb1 : in.pb0;
  assign ux_a   = pick_a ? 17'(in.a.s) : 17'(in.a.c);
  assign uy_a   = pick_a ? -17'(in.a.c) : 17'(in.a.s);
  assign ux_b   = pick_b ? 17'(in.b.s) : 17'(in.b.c);
  assign uy_b   = pick_b ? -17'(in.b.c) : 17'(in.b.s);

  // Fifth stage: axis of the smaller penetration per box, negated where its center projection is positive.
  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
      v6 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v5 <= in_valid;
      v6 <= v5;
      out_valid <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit5    <= in.hit;
      acx5    <= in.a.cx;
      acy5    <= in.a.cy;
      bcx5    <= in.b.cx;
      bcy5    <= in.b.cy;
      nax5    <= (p_a > 34'sd0) ? -ux_a : ux_a;
      nay5    <= (p_a > 34'sd0) ? -uy_a : uy_a;
      nbx5    <= (p_b > 34'sd0) ? -ux_b : ux_b;
      nby5    <= (p_b > 34'sd0) ? -uy_b : uy_b;
      dist_a5 <= (p_a > 34'sd0) ? -35'(p_a) : 35'(p_a);
      dist_b5 <= (p_b > 34'sd0) ? -35'(p_b) : 35'(p_b);
    end
  end

  // Sixth stage: normal times distance for each contact coordinate.
  always_ff @(posedge clk) begin
    if (en) begin
      hit6 <= hit5;
      acx6 <= acx5;
      acy6 <= acy5;
      bcx6 <= bcx5;
      bcy6 <= bcy5;
      nax6 <= nax5;
      nay6 <= nay5;
      nbx6 <= nbx5;
      nby6 <= nby5;
      oax6 <= OFF_PROD_W'(nax5) * OFF_PROD_W'(dist_a5);
      oay6 <= OFF_PROD_W'(nay5) * OFF_PROD_W'(dist_a5);
      obx6 <= OFF_PROD_W'(nbx5) * OFF_PROD_W'(dist_b5);
      oby6 <= OFF_PROD_W'(nby5) * OFF_PROD_W'(dist_b5);
    end
  end

  // Seventh stage: rounding, saturation and zeroing of a miss.
  always_ff @(posedge clk) begin
    if (en) begin
      out.hit <= hit6;
      if (hit6) begin
        out.first_contact_x  <= contact(acx6, oax6);
        out.first_contact_y  <= contact(acy6, oay6);
        out.first_normal_x   <= sat16(25'(nax6));
        out.first_normal_y   <= sat16(25'(nay6));
        out.second_contact_x <= contact(bcx6, obx6);
        out.second_contact_y <= contact(bcy6, oby6);
        out.second_normal_x  <= sat16(25'(nbx6));
        out.second_normal_y  <= sat16(25'(nby6));
      end else begin
        out.first_contact_x  <= '0;
        out.first_contact_y  <= '0;
        out.first_normal_x   <= '0;
        out.first_normal_y   <= '0;
        out.second_contact_x <= '0;
        out.second_contact_y <= '0;
        out.second_normal_x  <= '0;
        out.second_normal_y  <= '0;
      end
    end
  end

endmodule

@@ hdl/obb_checker.sv @@
module obb_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [135:0] m_tdata
);

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // A held result stays put.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("held result changed");

  // A miss carries all-zero fields.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[135:1] == '0)
    else $error("miss with nonzero fields");

  // No new request enters while the output is blocked.
  a_stall_in: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken during output stall");

  // A pipeline that keeps advancing with no new request until every stage has passed on its contents is empty.
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    (!(s_tvalid && s_tready) && (!m_tvalid || m_tready)) [*7] |=> !m_tvalid)
    else $error("result without a request");

endmodule

bind obb_pair_sat_collision_core obb_checker u_obb_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);
